@@ sv/b64d_pkg.sv @@
// b64d_pkg: shared types, character codes and the sextet mapping function
// for the base64 stream decoder. No dependencies.
`timescale 1ns / 1ps

package b64d_pkg;

    // depth of the group queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // byte index of the third byte of a group
    localparam logic [1:0] LAST_BYTE_IDX = 2'd2;
    // group position of the fourth character
    localparam logic [1:0] LAST_GROUP_POS = 2'd3;

    // ascii codes of the alphabet limits
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_PAD     = 8'h3D;

    // sextet offsets of the lower-case and digit ranges
    localparam logic [7:0] OFS_LOWER = 8'd26;
    localparam logic [7:0] OFS_DIGIT = 8'd52;
    localparam logic [5:0] VAL_PLUS  = 6'd62;
    localparam logic [5:0] VAL_SLASH = 6'd63;

    typedef logic [5:0] sextet_t;

    // result of classifying one character
    typedef struct packed {
        logic    hit;
        sextet_t val;
    } map_t;

    // one decoded group as it travels through the queue
    typedef struct packed {
        logic       text_last;
        logic [7:0] b2;
        logic [7:0] b1;
        logic [7:0] b0;
    } group_t;

    // queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // character to sextet; hit is low for characters outside the alphabet
    function automatic map_t map_char(logic [7:0] c);
        map_t       m;
        logic [7:0] t;
        m.hit = 1'b1;
        t     = '0;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            t = c - CH_UPPER_A;
        end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
            t = c - CH_LOWER_A + OFS_LOWER;
        end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
            t = c - CH_DIGIT_0 + OFS_DIGIT;
        end else if (c == CH_PLUS) begin
            t = {2'b00, VAL_PLUS};
        end else if (c == CH_SLASH) begin
            t = {2'b00, VAL_SLASH};
        end else if (c == CH_PAD) begin
            t = '0;
        end else begin
            m.hit = 1'b0;
        end
        m.val = t[5:0];
        return m;
    endfunction

endpackage

@@ sv/b64d_front.sv @@
// b64d_front: accepts characters, maps them to sextets, keeps the group
// slots and position, and pushes a finished group of three bytes.
// Depends on b64d_pkg.
`timescale 1ns / 1ps

module b64d_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_beat,
    input  logic [7:0]            code_char,
    input  logic                  end_of_text,
    output logic                  push,
    output b64d_pkg::group_t      push_data
);
    import b64d_pkg::*;

    logic [1:0] pos_reg, pos_next;
    sextet_t    slots_reg [4];
    map_t       m;
    sextet_t    s3;

    // classify the incoming character
    assign m  = map_char(code_char);
    assign s3 = m.hit ? m.val : slots_reg[3];

    // group completes on the fourth character
    assign push = in_beat && (pos_reg == LAST_GROUP_POS);

    // pack three bytes from the four sextets
    always_comb begin
        push_data.text_last = end_of_text;
        push_data.b0 = {slots_reg[0], slots_reg[1][5:4]};
        push_data.b1 = {slots_reg[1][3:0], slots_reg[2][5:2]};
        push_data.b2 = {slots_reg[2][1:0], s3};
    end

    // next group position
    always_comb begin
        pos_next = pos_reg;
        if (in_beat) begin
            if (end_of_text || pos_reg == LAST_GROUP_POS) begin
                pos_next = '0;
            end else begin
                pos_next = pos_reg + 2'd1;
            end
        end
    end

    // position and slot registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            for (int i = 0; i < 4; i++) begin
                slots_reg[i] <= '0;
            end
        end else begin
            pos_reg <= pos_next;
            if (in_beat && m.hit) begin
                slots_reg[pos_reg] <= m.val;
            end
        end
    end

    // a push only comes from an accepted fourth character
    a_push_src: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> in_beat && pos_reg == LAST_GROUP_POS)
        else $error("push without fourth character");

    // end of text always restarts the group
    a_eot_rst: assert property (@(posedge aclk) disable iff (!aresetn)
        in_beat && end_of_text |=> pos_reg == 2'd0)
        else $error("position not cleared after end of text");

    // position stays put while no character arrives
    a_pos_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_beat |=> pos_reg == $past(pos_reg))
        else $error("position moved without a character");

endmodule

@@ sv/b64d_queue.sv @@
// b64d_queue: short queue of decoded groups between front and back.
// Depends on b64d_pkg.
`timescale 1ns / 1ps

module b64d_queue #(
    parameter int DEPTH = b64d_pkg::QUEUE_DEPTH  // at least 2
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  b64d_pkg::group_t      push_data,
    input  logic                  pop,
    output b64d_pkg::group_t      pop_data,
    output b64d_pkg::q_status_t   status
);
    import b64d_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    group_t        mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] cnt_reg;
    logic          do_push, do_pop;

    assign status.full  = (cnt_reg == CNT_FULL);
    assign status.empty = (cnt_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_data     = mem[rd_ptr_reg];

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // fill count never passes the depth
    a_cnt_max: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_FULL)
        else $error("queue over depth");

    // no push is lost: pushes arrive only when there is room
    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !status.full)
        else $error("push into full queue");

    // no pop from an empty queue
    a_no_under: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !status.empty)
        else $error("pop from empty queue");

endmodule

@@ sv/b64d_back.sv @@
// b64d_back: takes decoded groups from the queue and sends their three
// bytes out one beat at a time from an output register.
// Depends on b64d_pkg.
`timescale 1ns / 1ps

module b64d_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  b64d_pkg::group_t      pop_data,
    input  b64d_pkg::q_status_t   q_status,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // data_byte
    output logic [0:0]            m_tuser,   // [0] group_last
    output logic                  m_tlast    // text_last
);
    import b64d_pkg::*;

    group_t     grp_reg;
    logic       busy_reg;
    logic [1:0] idx_reg;
    logic       out_beat;
    logic       third;

    assign third    = (idx_reg == LAST_BYTE_IDX);
    assign out_beat = busy_reg && m_tready;
    assign pop      = !q_status.empty && (!busy_reg || (m_tready && third));

    // byte select from the held group
    always_comb begin
        case (idx_reg)
            2'd0:    m_tdata = grp_reg.b0;
            2'd1:    m_tdata = grp_reg.b1;
            default: m_tdata = grp_reg.b2;
        endcase
    end

    assign m_tvalid   = busy_reg;
    assign m_tuser[0] = third;
    assign m_tlast    = third && grp_reg.text_last;

    // group register and byte counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else if (pop) begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end else if (out_beat) begin
            if (third) begin
                busy_reg <= 1'b0;
            end else begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            grp_reg <= pop_data;
        end
    end

    // a new group loads only when the last one is done or finishing
    a_pop_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !busy_reg || (m_tready && third))
        else $error("group overwritten before sent");

    // text end only on the third byte
    a_tlast_third: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tlast |-> m_tuser[0])
        else $error("text_last off the third byte");

    // byte counter stays within a group
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> idx_reg != 2'd3)
        else $error("byte index out of range");

endmodule

@@ sv/base64_stream_decoder_top.sv @@
// base64_stream_decoder_top: base64 text in, decoded bytes out.
// Depends on b64d_pkg, b64d_front, b64d_queue, b64d_back.
//
//   channel  dir  tdata             tuser            tlast
//   s_       in   code_char[7:0]    -                end_of_text
//   m_       out  data_byte[7:0]    [0] group_last   text_last
//
// one character beat per cycle while the queue has room; four characters yield
// three byte beats; the first byte of a group follows its fourth character beat
// via the queue write, then the output group register when the back end is idle
// reset clears the group position, all four sextet slots and the group queue
// s_tready drops only while the group queue is full; the queue decouples the
// input from stalls on m_tready
`timescale 1ns / 1ps

module base64_stream_decoder_top #(
    parameter int Q_DEPTH = b64d_pkg::QUEUE_DEPTH  // at least 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // code_char
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // data_byte
    output logic [0:0]  m_tuser,   // [0] group_last
    output logic        m_tlast    // text_last
);
    import b64d_pkg::*;

    logic      in_beat;
    logic      push;
    logic      pop;
    group_t    push_data;
    group_t    pop_data;
    q_status_t q_status;

    // input beat
    assign s_tready = !q_status.full;
    assign in_beat  = s_tvalid && s_tready;

    // character front end
    b64d_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_beat     (in_beat),
        .code_char   (s_tdata),
        .end_of_text (s_tlast),
        .push        (push),
        .push_data   (push_data)
    );

    // group queue
    b64d_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    // byte serializer
    b64d_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .pop_data (pop_data),
        .q_status (q_status),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
